### hdl/stok_pkg.sv
// stok_pkg: shared types, token class and operator codes for the source tokenizer
// no dependencies; used by stok_lex and source_tokenizer

package stok_pkg;

    // token classes
    localparam logic [4:0] CLS_EOF      = 5'd0;
    localparam logic [4:0] CLS_INT      = 5'd1;
    localparam logic [4:0] CLS_DEC      = 5'd2;
    localparam logic [4:0] CLS_NAME     = 5'd3;
    localparam logic [4:0] CLS_KW_DO    = 5'd4;
    localparam logic [4:0] CLS_KW_IF    = 5'd5;
    localparam logic [4:0] CLS_KW_ELSE  = 5'd6;
    localparam logic [4:0] CLS_KW_WHILE = 5'd7;
    localparam logic [4:0] CLS_KW_END   = 5'd8;
    localparam logic [4:0] CLS_KW_TRY   = 5'd9;
    localparam logic [4:0] CLS_KW_CATCH = 5'd10;
    localparam logic [4:0] CLS_STRING   = 5'd11;
    localparam logic [4:0] CLS_LPAREN   = 5'd12;
    localparam logic [4:0] CLS_RPAREN   = 5'd13;
    localparam logic [4:0] CLS_LBRACK   = 5'd14;
    localparam logic [4:0] CLS_RBRACK   = 5'd15;
    localparam logic [4:0] CLS_LBRACE   = 5'd16;
    localparam logic [4:0] CLS_RBRACE   = 5'd17;
    localparam logic [4:0] CLS_COMMA    = 5'd18;
    localparam logic [4:0] CLS_ASSIGN   = 5'd19;
    localparam logic [4:0] CLS_BINOP    = 5'd20;
    localparam logic [4:0] CLS_DOT      = 5'd21;
    localparam logic [4:0] CLS_COLON    = 5'd22;
    localparam logic [4:0] CLS_UNKNOWN  = 5'd23;

    // binary operator codes
    localparam logic [3:0] OP_NONE = 4'd0;
    localparam logic [3:0] OP_EQ   = 4'd0;
    localparam logic [3:0] OP_GE   = 4'd1;
    localparam logic [3:0] OP_GT   = 4'd2;
    localparam logic [3:0] OP_LE   = 4'd3;
    localparam logic [3:0] OP_LT   = 4'd4;
    localparam logic [3:0] OP_NE   = 4'd5;
    localparam logic [3:0] OP_ADD  = 4'd6;
    localparam logic [3:0] OP_SUB  = 4'd7;
    localparam logic [3:0] OP_MUL  = 4'd8;
    localparam logic [3:0] OP_MOD  = 4'd9;
    localparam logic [3:0] OP_DIV  = 4'd10;

    // binding strength
    localparam logic [4:0] PREC_NONE = 5'd0;
    localparam logic [4:0] PREC_CMP  = 5'd20;
    localparam logic [4:0] PREC_MUL  = 5'd15;
    localparam logic [4:0] PREC_ADD  = 5'd10;

    // keyword spellings, first letter in the lowest byte, unused bytes zero
    localparam logic [39:0] KW_DO    = 40'h00_0000_6f64;
    localparam logic [39:0] KW_IF    = 40'h00_0000_6669;
    localparam logic [39:0] KW_ELSE  = 40'h00_6573_6c65;
    localparam logic [39:0] KW_WHILE = 40'h65_6c69_6877;
    localparam logic [39:0] KW_END   = 40'h00_0064_6e65;
    localparam logic [39:0] KW_TRY   = 40'h00_0079_7274;
    localparam logic [39:0] KW_CATCH = 40'h68_6374_6163;

    // descriptive part of one token
    typedef struct packed {
        logic [4:0] cls;
        logic [3:0] op;
        logic [4:0] prec;
        logic       unterm;
    } t_tok_kind;

    function automatic t_tok_kind mk_kind(input logic [4:0] cls, input logic [3:0] op,
                                          input logic [4:0] prec, input logic unterm);
        t_tok_kind k;
        k.cls    = cls;
        k.op     = op;
        k.prec   = prec;
        k.unterm = unterm;
        return k;
    endfunction

    // class of a name of at most five letters held in the keyword buffer
    function automatic logic [4:0] kw_class(input logic [39:0] kb);
        logic [4:0] cls;
        cls = CLS_NAME;
        if (kb == KW_DO)    cls = CLS_KW_DO;
        if (kb == KW_IF)    cls = CLS_KW_IF;
        if (kb == KW_ELSE)  cls = CLS_KW_ELSE;
        if (kb == KW_WHILE) cls = CLS_KW_WHILE;
        if (kb == KW_END)   cls = CLS_KW_END;
        if (kb == KW_TRY)   cls = CLS_KW_TRY;
        if (kb == KW_CATCH) cls = CLS_KW_CATCH;
        return cls;
    endfunction

endpackage

### hdl/source_tokenizer.sv
// source_tokenizer: input stage, lexer step and a four-entry token queue to the output
// depends on stok_pkg and stok_lex
// a taken byte is held in the input stage; the lexer step queues its tokens for m_axis
// throughput: one byte per cycle while the queue has room; the lexer steps only while
// at most two tokens are queued, so the queue absorbs a byte that yields two tokens
// reset: synchronous, active low; empties the queue and sets line 1, offset 0, idle mode

module source_tokenizer #(
    parameter int LINE_BITS   = 16,
    parameter int OFFSET_BITS = 24,
    parameter int LENGTH_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // bytes in
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // text_byte
    input  logic                 s_axis_tlast,   // end_of_text
    // tokens out
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // operator_code, precedence, line_number, start_offset, token_length, unterminated
    output logic [((10+LINE_BITS+OFFSET_BITS+LENGTH_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic [4:0]           m_axis_tuser,   // token_class
    output logic                 m_axis_tlast    // last_of_run
);

    localparam int DATA_BITS = 10 + LINE_BITS + OFFSET_BITS + LENGTH_BITS;
    localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8;
    localparam int QDEPTH    = 4;
    localparam int PTR_W     = $clog2(QDEPTH);
    localparam int CNT_W     = $clog2(QDEPTH + 1);

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_eot;
    logic                   step;
    logic                   pop;

    stok_pkg::t_tok_kind    tok0_kind, tok1_kind;
    logic [OFFSET_BITS-1:0] tok0_start, tok1_start;
    logic [LENGTH_BITS-1:0] tok0_len, tok1_len;
    logic [1:0]             lex_cnt;
    logic [LINE_BITS-1:0]   lex_line;

    stok_pkg::t_tok_kind    r_q_kind  [QDEPTH];
    logic [OFFSET_BITS-1:0] r_q_start [QDEPTH];
    logic [LENGTH_BITS-1:0] r_q_len   [QDEPTH];
    logic [LINE_BITS-1:0]   r_q_line  [QDEPTH];
    logic                   r_q_last  [QDEPTH];
    logic [PTR_W-1:0]       r_wptr, r_rptr;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [PTR_W-1:0]       wptr_next;
    logic [DATA_BITS-1:0]   out_data;
    stok_pkg::t_tok_kind    head_kind;

    // step when a byte is held and the queue has room for two tokens
    assign step          = r_in_valid && (r_cnt <= CNT_W'(QDEPTH - 2));
    assign s_axis_tready = !r_in_valid || step;
    assign pop           = m_axis_tvalid && m_axis_tready;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_eot  <= s_axis_tlast;
        end
    end

    stok_lex #(
        .LINE_BITS   (LINE_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_lex (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte       (r_in_byte),
        .i_eot        (r_in_eot),
        .o_tok0_kind  (tok0_kind),
        .o_tok0_start (tok0_start),
        .o_tok0_len   (tok0_len),
        .o_tok1_kind  (tok1_kind),
        .o_tok1_start (tok1_start),
        .o_tok1_len   (tok1_len),
        .o_cnt        (lex_cnt),
        .o_line       (lex_line)
    );

    // queue payload writes
    assign wptr_next = r_wptr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (step && lex_cnt != 2'd0) begin
            r_q_kind[r_wptr]  <= tok0_kind;
            r_q_start[r_wptr] <= tok0_start;
            r_q_len[r_wptr]   <= tok0_len;
            r_q_line[r_wptr]  <= lex_line;
            r_q_last[r_wptr]  <= (lex_cnt == 2'd1);
        end
        if (step && lex_cnt == 2'd2) begin
            r_q_kind[wptr_next]  <= tok1_kind;
            r_q_start[wptr_next] <= tok1_start;
            r_q_len[wptr_next]   <= tok1_len;
            r_q_line[wptr_next]  <= lex_line;
            r_q_last[wptr_next]  <= 1'b1;
        end
    end

    // queue pointers and fill count
    always_comb begin
        n_cnt = r_cnt;
        if (step) n_cnt = n_cnt + CNT_W'(lex_cnt);
        if (pop)  n_cnt = n_cnt - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (step) r_wptr <= r_wptr + PTR_W'(lex_cnt);
            if (pop)  r_rptr <= r_rptr + PTR_W'(1);
            r_cnt <= n_cnt;
        end
    end

    // head of queue onto the output port
    assign head_kind     = r_q_kind[r_rptr];
    assign m_axis_tvalid = (r_cnt != '0);
    assign out_data      = {head_kind.unterm, r_q_len[r_rptr], r_q_start[r_rptr],
                            r_q_line[r_rptr], head_kind.prec, head_kind.op};
    assign m_axis_tdata  = TDATA_W'(out_data);
    assign m_axis_tuser  = head_kind.cls;
    assign m_axis_tlast  = r_q_last[r_rptr];

`ifndef SYNTHESIS
    // queue never overfills
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(QDEPTH))
        else $error("token queue overflow");

    // the end marker always yields at least the eof token
    a_eot_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in_eot) |-> (lex_cnt != 2'd0))
        else $error("end of text produced no token");

    // after the end marker the line counter restarts
    a_eot_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in_eot) |=> (lex_line == LINE_BITS'(1)))
        else $error("line counter not restarted after end of text");

    // eof is always the final token of its run
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == stok_pkg::CLS_EOF) |-> m_axis_tlast)
        else $error("eof token not marked last");
`endif

endmodule

### hdl/stok_lex.sv
// stok_lex: lexer state registers and the per-byte step logic
// yields up to two tokens per step, in order; depends on stok_pkg

module stok_lex #(
    parameter int LINE_BITS   = 16,
    parameter int OFFSET_BITS = 24,
    parameter int LENGTH_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic [7:0]               i_byte,
    input  logic                     i_eot,
    output stok_pkg::t_tok_kind      o_tok0_kind,
    output logic [OFFSET_BITS-1:0]   o_tok0_start,
    output logic [LENGTH_BITS-1:0]   o_tok0_len,
    output stok_pkg::t_tok_kind      o_tok1_kind,
    output logic [OFFSET_BITS-1:0]   o_tok1_start,
    output logic [LENGTH_BITS-1:0]   o_tok1_len,
    output logic [1:0]               o_cnt,
    output logic [LINE_BITS-1:0]     o_line
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_INT   = 10'b00_0000_0010,
        ST_DEC   = 10'b00_0000_0100,
        ST_NAME  = 10'b00_0000_1000,
        ST_STR   = 10'b00_0001_0000,
        ST_ESC   = 10'b00_0010_0000,
        ST_LCOM  = 10'b00_0100_0000,
        ST_BCOM  = 10'b00_1000_0000,
        ST_BSTAR = 10'b01_0000_0000,
        ST_OP    = 10'b10_0000_0000
    } t_mode;

    typedef enum logic [2:0] {
        PEND_NONE, PEND_EQ, PEND_GT, PEND_LT, PEND_BANG, PEND_SLASH, PEND_HASH
    } t_pend;

    t_mode                  r_mode, n_mode;
    t_pend                  r_pend, n_pend;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [39:0]            r_kb, n_kb;

    logic [LINE_BITS-1:0]   line_inc;
    logic [LENGTH_BITS-1:0] len_inc;
    logic [OFFSET_BITS-1:0] offset_inc;
    logic                   is_digit, is_alpha, is_space, is_nl;

    stok_pkg::t_tok_kind    f_kind, a_kind, b_kind;
    logic                   f_valid, a_valid, b_valid;
    logic [LENGTH_BITS-1:0] a_len, b_len;
    logic [OFFSET_BITS-1:0] b_start;
    logic                   flush_do, to_idle;

    // saturating counters
    assign line_inc   = (r_line == '1) ? r_line : r_line + LINE_BITS'(1);
    assign len_inc    = (r_len == '1) ? r_len : r_len + LENGTH_BITS'(1);
    assign offset_inc = (r_offset == '1) ? r_offset : r_offset + OFFSET_BITS'(1);

    // byte classes
    assign is_digit = i_byte inside {["0":"9"]};
    assign is_alpha = i_byte inside {["a":"z"], ["A":"Z"]};
    assign is_space = i_byte inside {[8'd9:8'd13], " "};
    assign is_nl    = (i_byte == 8'd10);

    // token that closes out the open one when a byte does not belong to it
    always_comb begin
        f_valid = 1'b0;
        f_kind  = stok_pkg::mk_kind(stok_pkg::CLS_EOF, stok_pkg::OP_NONE,
                                    stok_pkg::PREC_NONE, 1'b0);
        case (r_mode)
            ST_INT: begin
                f_valid    = 1'b1;
                f_kind.cls = stok_pkg::CLS_INT;
            end
            ST_DEC: begin
                f_valid    = 1'b1;
                f_kind.cls = stok_pkg::CLS_DEC;
            end
            ST_NAME: begin
                f_valid    = 1'b1;
                f_kind.cls = (r_len <= LENGTH_BITS'(5)) ? stok_pkg::kw_class(r_kb)
                                                        : stok_pkg::CLS_NAME;
            end
            ST_STR, ST_ESC: begin
                f_valid       = 1'b1;
                f_kind.cls    = stok_pkg::CLS_STRING;
                f_kind.unterm = 1'b1;
            end
            ST_OP: begin
                case (r_pend)
                    PEND_EQ: begin
                        f_valid    = 1'b1;
                        f_kind.cls = stok_pkg::CLS_ASSIGN;
                    end
                    PEND_GT: begin
                        f_valid = 1'b1;
                        f_kind  = stok_pkg::mk_kind(stok_pkg::CLS_BINOP, stok_pkg::OP_GT,
                                                    stok_pkg::PREC_MUL, 1'b0);
                    end
                    PEND_LT: begin
                        f_valid = 1'b1;
                        f_kind  = stok_pkg::mk_kind(stok_pkg::CLS_BINOP, stok_pkg::OP_LT,
                                                    stok_pkg::PREC_CMP, 1'b0);
                    end
                    PEND_BANG: begin
                        f_valid    = 1'b1;
                        f_kind.cls = stok_pkg::CLS_UNKNOWN;
                    end
                    PEND_SLASH: begin
                        f_valid = 1'b1;
                        f_kind  = stok_pkg::mk_kind(stok_pkg::CLS_BINOP, stok_pkg::OP_DIV,
                                                    stok_pkg::PREC_MUL, 1'b0);
                    end
                    default: f_valid = 1'b0;
                endcase
            end
            default: f_valid = 1'b0;
        endcase
    end

    // one step of the lexer: slot a is the open token, slot b a new one-byte token or eof
    always_comb begin
        n_mode   = r_mode;
        n_pend   = r_pend;
        n_line   = r_line;
        n_offset = offset_inc;
        n_start  = r_start;
        n_len    = r_len;
        n_kb     = r_kb;
        a_valid  = 1'b0;
        a_kind   = f_kind;
        a_len    = r_len;
        b_valid  = 1'b0;
        b_kind   = stok_pkg::mk_kind(stok_pkg::CLS_EOF, stok_pkg::OP_NONE,
                                     stok_pkg::PREC_NONE, 1'b0);
        b_start  = r_offset;
        b_len    = LENGTH_BITS'(1);
        flush_do = 1'b0;
        to_idle  = 1'b0;

        if (i_eot) begin
            // flush, then eof, then back to the reset state
            a_valid  = f_valid;
            b_valid  = 1'b1;
            b_len    = '0;
            n_mode   = ST_IDLE;
            n_pend   = PEND_NONE;
            n_line   = LINE_BITS'(1);
            n_offset = '0;
            n_start  = '0;
            n_len    = '0;
            n_kb     = '0;
        end else begin
            case (r_mode)
                ST_IDLE: to_idle = 1'b1;
                ST_INT: begin
                    if (is_digit) begin
                        n_len = len_inc;
                    end else if (i_byte == ".") begin
                        n_len  = len_inc;
                        n_mode = ST_DEC;
                    end else begin
                        flush_do = 1'b1;
                    end
                end
                ST_DEC: begin
                    if (is_digit) begin
                        n_len = len_inc;
                    end else begin
                        flush_do = 1'b1;
                    end
                end
                ST_NAME: begin
                    if (is_alpha) begin
                        for (int i = 0; i < 5; i++) begin
                            if (r_len == LENGTH_BITS'(i)) n_kb[8*i +: 8] = i_byte;
                        end
                        n_len = len_inc;
                    end else begin
                        flush_do = 1'b1;
                    end
                end
                ST_STR: begin
                    if (i_byte == "\"") begin
                        a_valid = 1'b1;
                        a_kind  = stok_pkg::mk_kind(stok_pkg::CLS_STRING, stok_pkg::OP_NONE,
                                                    stok_pkg::PREC_NONE, 1'b0);
                        n_mode  = ST_IDLE;
                    end else begin
                        if (i_byte == "\\") n_mode = ST_ESC;
                        if (is_nl) n_line = line_inc;
                        n_len = len_inc;
                    end
                end
                ST_ESC: begin
                    if (is_nl) n_line = line_inc;
                    n_len  = len_inc;
                    n_mode = ST_STR;
                end
                ST_LCOM: begin
                    if (is_nl) begin
                        n_line = line_inc;
                        n_mode = ST_IDLE;
                    end
                end
                ST_BCOM: begin
                    if (i_byte == "*") begin
                        n_mode = ST_BSTAR;
                    end else if (is_nl) begin
                        n_line = line_inc;
                    end
                end
                ST_BSTAR: begin
                    if (i_byte == "/") begin
                        n_mode = ST_IDLE;
                    end else if (i_byte != "*") begin
                        n_mode = ST_BCOM;
                        if (is_nl) n_line = line_inc;
                    end
                end
                ST_OP: begin
                    if (i_byte == "=" && (r_pend == PEND_EQ || r_pend == PEND_GT ||
                                          r_pend == PEND_LT || r_pend == PEND_BANG)) begin
                        // two-character comparison
                        a_valid = 1'b1;
                        a_len   = LENGTH_BITS'(2);
                        a_kind  = stok_pkg::mk_kind(stok_pkg::CLS_BINOP, stok_pkg::OP_EQ,
                                                    stok_pkg::PREC_CMP, 1'b0);
                        case (r_pend)
                            PEND_GT: a_kind.op = stok_pkg::OP_GE;
                            PEND_LT: a_kind.op = stok_pkg::OP_LE;
                            PEND_BANG: a_kind.op = stok_pkg::OP_NE;
                            default: a_kind.op = stok_pkg::OP_EQ;
                        endcase
                        n_pend = PEND_NONE;
                        n_mode = ST_IDLE;
                    end else if ((r_pend == PEND_SLASH && i_byte == "/") ||
                                 (r_pend == PEND_HASH && i_byte == "!")) begin
                        n_pend = PEND_NONE;
                        n_mode = ST_LCOM;
                    end else if (r_pend == PEND_SLASH && i_byte == "*") begin
                        n_pend = PEND_NONE;
                        n_mode = ST_BCOM;
                    end else begin
                        flush_do = 1'b1;
                    end
                end
                default: to_idle = 1'b1;
            endcase

            // open token ends here and the byte starts over in idle
            if (flush_do) begin
                a_valid = f_valid;
                a_kind  = f_kind;
                to_idle = 1'b1;
            end

            if (to_idle) begin
                n_mode = ST_IDLE;
                n_pend = PEND_NONE;
                if (is_space) begin
                    if (is_nl) n_line = line_inc;
                end else if (is_digit) begin
                    n_mode  = ST_INT;
                    n_start = r_offset;
                    n_len   = LENGTH_BITS'(1);
                end else if (is_alpha) begin
                    n_mode  = ST_NAME;
                    n_start = r_offset;
                    n_len   = LENGTH_BITS'(1);
                    n_kb    = {32'd0, i_byte};
                end else begin
                    case (i_byte)
                        "\"": begin
                            n_mode  = ST_STR;
                            n_start = r_offset;
                            n_len   = '0;
                        end
                        "=", ">", "<", "!", "/", "#": begin
                            n_mode  = ST_OP;
                            n_start = r_offset;
                            n_len   = LENGTH_BITS'(1);
                            case (i_byte)
                                "=": n_pend = PEND_EQ;
                                ">": n_pend = PEND_GT;
                                "<": n_pend = PEND_LT;
                                "!": n_pend = PEND_BANG;
                                "/": n_pend = PEND_SLASH;
                                default: n_pend = PEND_HASH;
                            endcase
                        end
                        "(": begin
                            b_valid    = 1'b1;
                            b_kind.cls = stok_pkg::CLS_LPAREN;
                        end
                        ")": begin
                            b_valid    = 1'b1;
                            b_kind.cls = stok_pkg::CLS_RPAREN;
                        end
                        "[": begin
                            b_valid    = 1'b1;
                            b_kind.cls = stok_pkg::CLS_LBRACK;
                        end
                        "]": begin
                            b_valid    = 1'b1;
                            b_kind.cls = stok_pkg::CLS_RBRACK;
                        end
                        "{": begin
                            b_valid    = 1'b1;
                            b_kind.cls = stok_pkg::CLS_LBRACE;
                        end
                        "}": begin
                            b_valid    = 1'b1;
                            b_kind.cls = stok_pkg::CLS_RBRACE;
                        end
                        ",": begin
                            b_valid    = 1'b1;
                            b_kind.cls = stok_pkg::CLS_COMMA;
                        end
                        "+": begin
                            b_valid = 1'b1;
                            b_kind  = stok_pkg::mk_kind(stok_pkg::CLS_BINOP, stok_pkg::OP_ADD,
                                                        stok_pkg::PREC_ADD, 1'b0);
                        end
                        "-": begin
                            b_valid = 1'b1;
                            b_kind  = stok_pkg::mk_kind(stok_pkg::CLS_BINOP, stok_pkg::OP_SUB,
                                                        stok_pkg::PREC_ADD, 1'b0);
                        end
                        "*": begin
                            b_valid = 1'b1;
                            b_kind  = stok_pkg::mk_kind(stok_pkg::CLS_BINOP, stok_pkg::OP_MUL,
                                                        stok_pkg::PREC_MUL, 1'b0);
                        end
                        "%": begin
                            b_valid = 1'b1;
                            b_kind  = stok_pkg::mk_kind(stok_pkg::CLS_BINOP, stok_pkg::OP_MOD,
                                                        stok_pkg::PREC_MUL, 1'b0);
                        end
                        ".": begin
                            b_valid    = 1'b1;
                            b_kind.cls = stok_pkg::CLS_DOT;
                        end
                        ":": begin
                            b_valid    = 1'b1;
                            b_kind.cls = stok_pkg::CLS_COLON;
                        end
                        default: begin
                            b_valid    = 1'b1;
                            b_kind.cls = stok_pkg::CLS_UNKNOWN;
                        end
                    endcase
                end
            end
        end
    end

    // pack the tokens of this step so the first one is always in slot zero
    always_comb begin
        if (a_valid) begin
            o_tok0_kind  = a_kind;
            o_tok0_start = r_start;
            o_tok0_len   = a_len;
            o_cnt        = b_valid ? 2'd2 : 2'd1;
        end else begin
            o_tok0_kind  = b_kind;
            o_tok0_start = b_start;
            o_tok0_len   = b_len;
            o_cnt        = b_valid ? 2'd1 : 2'd0;
        end
        o_tok1_kind  = b_kind;
        o_tok1_start = b_start;
        o_tok1_len   = b_len;
    end

    assign o_line = r_line;

    // lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ST_IDLE;
            r_pend   <= PEND_NONE;
            r_line   <= LINE_BITS'(1);
            r_offset <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_kb     <= '0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_pend   <= n_pend;
            r_line   <= n_line;
            r_offset <= n_offset;
            r_start  <= n_start;
            r_len    <= n_len;
            r_kb     <= n_kb;
        end
    end

endmodule

### tb/tb_source_tokenizer.sv
// tb_source_tokenizer: self-checking bench for the source tokenizer
// streams source text into the byte port and checks every token against a built-in lexer model
// depends on stok_pkg and source_tokenizer

module tb_source_tokenizer;
    import stok_pkg::*;

    localparam int LINE_W         = 16;
    localparam int OFFSET_W       = 24;
    localparam int LENGTH_W       = 16;
    localparam int TDATA_W        = ((10 + LINE_W + OFFSET_W + LENGTH_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int SAT_RUN        = 65540;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int DIR_ROWS       = 32;

    // lexer modes and the operator waiting for its second byte
    typedef enum logic [3:0] {
        LX_IDLE, LX_INT, LX_DEC, LX_NAME, LX_STR, LX_ESC, LX_LCOM, LX_BCOM, LX_BSTAR, LX_OP
    } lex_mode_e;

    typedef enum logic [2:0] {
        PO_NONE, PO_EQ, PO_GT, PO_LT, PO_BANG, PO_SLASH, PO_HASH
    } pend_op_e;

    // output tdata layout, lowest field last
    typedef struct packed {
        logic [TDATA_W-67:0] pad;
        logic                unterm;
        logic [LENGTH_W-1:0] len;
        logic [OFFSET_W-1:0] start;
        logic [LINE_W-1:0]   line;
        logic [4:0]          prec;
        logic [3:0]          op;
    } tok_data_t;

    typedef struct {
        logic [4:0]          cls;
        logic [3:0]          op;
        logic [4:0]          prec;
        logic [LINE_W-1:0]   line;
        logic [OFFSET_W-1:0] start;
        logic [LENGTH_W-1:0] len;
        logic                unterm;
        logic                last;
    } token_t;

    // directed row: one byte, with the token it finishes typed in where obvious
    typedef struct {
        logic [7:0]  ch;
        logic        eot;
        bit          typed;
        logic [4:0]  cls;
        logic [3:0]  op;
        logic [4:0]  prec;
        logic [15:0] len;
    } dir_row_t;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{"(",   1'b0, 1'b1, CLS_LPAREN,  OP_NONE, PREC_NONE, 16'd1},
        '{"9",   1'b0, 1'b0, CLS_EOF,     OP_NONE, PREC_NONE, 16'd0},
        '{".",   1'b0, 1'b0, CLS_EOF,     OP_NONE, PREC_NONE, 16'd0},
        '{".",   1'b0, 1'b1, CLS_DOT,     OP_NONE, PREC_NONE, 16'd1},
        '{"7",   1'b0, 1'b0, CLS_EOF,     OP_NONE, PREC_NONE, 16'd0},
        '{"q",   1'b0, 1'b1, CLS_INT,     OP_NONE, PREC_NONE, 16'd1},
        '{">",   1'b0, 1'b0, CLS_EOF,     OP_NONE, PREC_NONE, 16'd0},
        '{"=",   1'b0, 1'b1, CLS_BINOP,   OP_GE,   PREC_CMP,  16'd2},
        '{"<",   1'b0, 1'b0, CLS_EOF,     OP_NONE, PREC_NONE, 16'd0},
        '{"=",   1'b0, 1'b1, CLS_BINOP,   OP_LE,   PREC_CMP,  16'd2},
        '{"!",   1'b0, 1'b0, CLS_EOF,     OP_NONE, PREC_NONE, 16'd0},
        '{"=",   1'b0, 1'b1, CLS_BINOP,   OP_NE,   PREC_CMP,  16'd2},
        '{"=",   1'b0, 1'b0, CLS_EOF,     OP_NONE, PREC_NONE, 16'd0},
        '{"=",   1'b0, 1'b1, CLS_BINOP,   OP_EQ,   PREC_CMP,  16'd2},
        '{"!",   1'b0, 1'b0, CLS_EOF,     OP_NONE, PREC_NONE, 16'd0},
        '{"<",   1'b0, 1'b1, CLS_UNKNOWN, OP_NONE, PREC_NONE, 16'd1},
        '{">",   1'b0, 1'b1, CLS_BINOP,   OP_LT,   PREC_CMP,  16'd1},
        '{"/",   1'b0, 1'b1, CLS_BINOP,   OP_GT,   PREC_MUL,  16'd1},
        '{"=",   1'b0, 1'b1, CLS_BINOP,   OP_DIV,  PREC_MUL,  16'd1},
        '{"+",   1'b0, 1'b1, CLS_BINOP,   OP_ADD,  PREC_ADD,  16'd1},
        '{"-",   1'b0, 1'b1, CLS_BINOP,   OP_SUB,  PREC_ADD,  16'd1},
        '{"*",   1'b0, 1'b1, CLS_BINOP,   OP_MUL,  PREC_MUL,  16'd1},
        '{"%",   1'b0, 1'b1, CLS_BINOP,   OP_MOD,  PREC_MUL,  16'd1},
        '{"\"",  1'b0, 1'b0, CLS_EOF,     OP_NONE, PREC_NONE, 16'd0},
        '{"\\",  1'b0, 1'b0, CLS_EOF,     OP_NONE, PREC_NONE, 16'd0},
        '{"\"",  1'b0, 1'b0, CLS_EOF,     OP_NONE, PREC_NONE, 16'd0},
        '{"\"",  1'b0, 1'b1, CLS_STRING,  OP_NONE, PREC_NONE, 16'd2},
        '{8'h00, 1'b0, 1'b1, CLS_UNKNOWN, OP_NONE, PREC_NONE, 16'd1},
        '{8'hFF, 1'b0, 1'b1, CLS_UNKNOWN, OP_NONE, PREC_NONE, 16'd1},
        '{"/",   1'b0, 1'b0, CLS_EOF,     OP_NONE, PREC_NONE, 16'd0},
        '{"/",   1'b0, 1'b0, CLS_EOF,     OP_NONE, PREC_NONE, 16'd0},
        '{8'hA5, 1'b1, 1'b1, CLS_EOF,     OP_NONE, PREC_NONE, 16'd0}
    };

    string kw_words [7]    = '{"do", "if", "else", "while", "end", "try", "catch"};
    string op_words [13]   = '{"==", ">=", ">", "<=", "<", "!=", "+", "-", "*", "%", "/", "=", "!"};
    string punct_chars     = "()[]{},.:";
    logic [7:0] space_chars [6] = '{" ", "\t", "\n", "\r", 8'd11, 8'd12};

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata  = 8'd0;
    logic                s_axis_tlast  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic [4:0]          m_axis_tuser;
    logic                m_axis_tlast;

    // lexer model state
    lex_mode_e           tz_mode;
    pend_op_e            tz_pend;
    logic [LINE_W-1:0]   tz_line;
    logic [OFFSET_W-1:0] tz_offset;
    logic [OFFSET_W-1:0] tz_start;
    logic [LENGTH_W-1:0] tz_len;
    logic [39:0]         tz_kwbuf;

    token_t              step_toks [$];
    token_t              due_tokens [$];
    logic [8:0]          lex_items [$];   // {end_of_text, text_byte}

    int                  fail_count  = 0;
    int                  items_sent  = 0;
    int                  burst_left  = 0;
    int                  idle_cycles = 0;
    int                  rx_style    = 0;
    int                  rx_left     = 0;

    source_tokenizer #(
        .LINE_BITS   (LINE_W),
        .OFFSET_BITS (OFFSET_W),
        .LENGTH_BITS (LENGTH_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // text_byte
        .s_axis_tlast  (s_axis_tlast),    // end_of_text
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // op, prec, line, start, length, unterminated
        .m_axis_tuser  (m_axis_tuser),    // token_class
        .m_axis_tlast  (m_axis_tlast)     // last_of_run
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- lexer model ----------------

    function automatic void tz_reset();
        tz_mode   = LX_IDLE;
        tz_pend   = PO_NONE;
        tz_line   = 1;
        tz_offset = '0;
        tz_start  = '0;
        tz_len    = '0;
        tz_kwbuf  = '0;
    endfunction

    function automatic void add_token(logic [4:0] cls, logic [3:0] op, logic [4:0] prec,
                                      logic [OFFSET_W-1:0] start, logic [LENGTH_W-1:0] len,
                                      logic unterm);
        token_t t;
        t.cls    = cls;
        t.op     = op;
        t.prec   = prec;
        t.line   = tz_line;
        t.start  = start;
        t.len    = len;
        t.unterm = unterm;
        t.last   = 1'b0;
        step_toks.push_back(t);
    endfunction

    function automatic void next_line();
        if (tz_line != '1) tz_line++;
    endfunction

    function automatic void grow_token();
        if (tz_len != '1) tz_len++;
    endfunction

    function automatic void open_token(lex_mode_e m, logic [LENGTH_W-1:0] len);
        tz_mode  = m;
        tz_start = tz_offset;
        tz_len   = len;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // keyword only when the whole name matches; longer names share the buffer prefix
    function automatic logic [4:0] word_class();
        logic [4:0] cls;
        cls = CLS_NAME;
        case (tz_len)
            2: begin
                if (tz_kwbuf == KW_DO) cls = CLS_KW_DO;
                else if (tz_kwbuf == KW_IF) cls = CLS_KW_IF;
            end
            3: begin
                if (tz_kwbuf == KW_END) cls = CLS_KW_END;
                else if (tz_kwbuf == KW_TRY) cls = CLS_KW_TRY;
            end
            4: begin
                if (tz_kwbuf == KW_ELSE) cls = CLS_KW_ELSE;
            end
            5: begin
                if (tz_kwbuf == KW_WHILE) cls = CLS_KW_WHILE;
                else if (tz_kwbuf == KW_CATCH) cls = CLS_KW_CATCH;
            end
            default: ;
        endcase
        return cls;
    endfunction

    // pending operator that got no second byte
    function automatic void close_operator();
        case (tz_pend)
            PO_EQ:    add_token(CLS_ASSIGN, OP_NONE, PREC_NONE, tz_start, 1, 1'b0);
            PO_GT:    add_token(CLS_BINOP, OP_GT, PREC_MUL, tz_start, 1, 1'b0);
            PO_LT:    add_token(CLS_BINOP, OP_LT, PREC_CMP, tz_start, 1, 1'b0);
            PO_BANG:  add_token(CLS_UNKNOWN, OP_NONE, PREC_NONE, tz_start, 1, 1'b0);
            PO_SLASH: add_token(CLS_BINOP, OP_DIV, PREC_MUL, tz_start, 1, 1'b0);
            default: ;
        endcase
        tz_pend = PO_NONE;
    endfunction

    function automatic void flush_token();
        case (tz_mode)
            LX_INT:  add_token(CLS_INT, OP_NONE, PREC_NONE, tz_start, tz_len, 1'b0);
            LX_DEC:  add_token(CLS_DEC, OP_NONE, PREC_NONE, tz_start, tz_len, 1'b0);
            LX_NAME: add_token(word_class(), OP_NONE, PREC_NONE, tz_start, tz_len, 1'b0);
            LX_STR, LX_ESC: add_token(CLS_STRING, OP_NONE, PREC_NONE, tz_start, tz_len, 1'b1);
            LX_OP:   close_operator();
            default: ;
        endcase
        tz_mode = LX_IDLE;
    endfunction

    // byte seen with no token open
    function automatic void idle_char(logic [7:0] c);
        logic [OFFSET_W-1:0] at;
        at = tz_offset;
        if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            if (c == "\n") next_line();
        end else if (is_digit(c)) begin
            open_token(LX_INT, 1);
        end else if (is_letter(c)) begin
            open_token(LX_NAME, 1);
            tz_kwbuf = {32'd0, c};
        end else begin
            case (c)
                "\"": open_token(LX_STR, 0);
                "(":  add_token(CLS_LPAREN, OP_NONE, PREC_NONE, at, 1, 1'b0);
                ")":  add_token(CLS_RPAREN, OP_NONE, PREC_NONE, at, 1, 1'b0);
                "[":  add_token(CLS_LBRACK, OP_NONE, PREC_NONE, at, 1, 1'b0);
                "]":  add_token(CLS_RBRACK, OP_NONE, PREC_NONE, at, 1, 1'b0);
                "{":  add_token(CLS_LBRACE, OP_NONE, PREC_NONE, at, 1, 1'b0);
                "}":  add_token(CLS_RBRACE, OP_NONE, PREC_NONE, at, 1, 1'b0);
                ",":  add_token(CLS_COMMA, OP_NONE, PREC_NONE, at, 1, 1'b0);
                "+":  add_token(CLS_BINOP, OP_ADD, PREC_ADD, at, 1, 1'b0);
                "-":  add_token(CLS_BINOP, OP_SUB, PREC_ADD, at, 1, 1'b0);
                "*":  add_token(CLS_BINOP, OP_MUL, PREC_MUL, at, 1, 1'b0);
                "%":  add_token(CLS_BINOP, OP_MOD, PREC_MUL, at, 1, 1'b0);
                ".":  add_token(CLS_DOT, OP_NONE, PREC_NONE, at, 1, 1'b0);
                ":":  add_token(CLS_COLON, OP_NONE, PREC_NONE, at, 1, 1'b0);
                "=": begin open_token(LX_OP, 1); tz_pend = PO_EQ; end
                ">": begin open_token(LX_OP, 1); tz_pend = PO_GT; end
                "<": begin open_token(LX_OP, 1); tz_pend = PO_LT; end
                "!": begin open_token(LX_OP, 1); tz_pend = PO_BANG; end
                "/": begin open_token(LX_OP, 1); tz_pend = PO_SLASH; end
                "#": begin open_token(LX_OP, 1); tz_pend = PO_HASH; end
                default: add_token(CLS_UNKNOWN, OP_NONE, PREC_NONE, at, 1, 1'b0);
            endcase
        end
    endfunction

    // byte seen by an open token or skip mode; returns 0 when it must start afresh
    function automatic bit token_char(logic [7:0] c);
        bit         taken;
        logic [3:0] op;
        taken = 1'b1;
        case (tz_mode)
            LX_INT: begin
                if (is_digit(c)) grow_token();
                else if (c == ".") begin grow_token(); tz_mode = LX_DEC; end
                else begin flush_token(); taken = 1'b0; end
            end
            LX_DEC: begin
                if (is_digit(c)) grow_token();
                else begin flush_token(); taken = 1'b0; end
            end
            LX_NAME: begin
                if (is_letter(c)) begin
                    if (tz_len < 5) tz_kwbuf[8*tz_len +: 8] = c;
                    grow_token();
                end else begin
                    flush_token();
                    taken = 1'b0;
                end
            end
            LX_STR: begin
                if (c == "\"") begin
                    add_token(CLS_STRING, OP_NONE, PREC_NONE, tz_start, tz_len, 1'b0);
                    tz_mode = LX_IDLE;
                end else begin
                    if (c == "\\") tz_mode = LX_ESC;
                    if (c == "\n") next_line();
                    grow_token();
                end
            end
            LX_ESC: begin
                if (c == "\n") next_line();
                grow_token();
                tz_mode = LX_STR;
            end
            LX_LCOM: begin
                if (c == "\n") begin next_line(); tz_mode = LX_IDLE; end
            end
            LX_BCOM: begin
                if (c == "*") tz_mode = LX_BSTAR;
                else if (c == "\n") next_line();
            end
            LX_BSTAR: begin
                if (c == "/") tz_mode = LX_IDLE;
                else if (c != "*") begin
                    tz_mode = LX_BCOM;
                    if (c == "\n") next_line();
                end
            end
            LX_OP: begin
                if (c == "=" && (tz_pend == PO_EQ || tz_pend == PO_GT ||
                                 tz_pend == PO_LT || tz_pend == PO_BANG)) begin
                    case (tz_pend)
                        PO_EQ:   op = OP_EQ;
                        PO_GT:   op = OP_GE;
                        PO_LT:   op = OP_LE;
                        default: op = OP_NE;
                    endcase
                    add_token(CLS_BINOP, op, PREC_CMP, tz_start, 2, 1'b0);
                    tz_pend = PO_NONE;
                    tz_mode = LX_IDLE;
                end else if ((tz_pend == PO_SLASH && c == "/") ||
                             (tz_pend == PO_HASH && c == "!")) begin
                    tz_pend = PO_NONE;
                    tz_mode = LX_LCOM;
                end else if (tz_pend == PO_SLASH && c == "*") begin
                    tz_pend = PO_NONE;
                    tz_mode = LX_BCOM;
                end else begin
                    flush_token();
                    taken = 1'b0;
                end
            end
            default: begin
                tz_mode = LX_IDLE;
                taken   = 1'b0;
            end
        endcase
        return taken;
    endfunction

    // tokens caused by one accepted byte, appended to the due list
    function automatic void tokenize_byte(logic [7:0] c, logic eot);
        step_toks.delete();
        if (eot) begin
            flush_token();
            add_token(CLS_EOF, OP_NONE, PREC_NONE, tz_offset, 0, 1'b0);
            tz_reset();
        end else begin
            if (!token_char(c)) idle_char(c);
            if (tz_offset != '1) tz_offset++;
        end
        if (step_toks.size() != 0) step_toks[step_toks.size()-1].last = 1'b1;
        foreach (step_toks[i]) due_tokens.push_back(step_toks[i]);
    endfunction

    // ---------------- stimulus ----------------

    // one byte transfer, sent in bursts with random gaps between them
    task automatic send_byte(input logic [7:0] c, input logic eot);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
                gap        = 0;
                burst_left = $urandom_range(100, 400);
            end else begin
                gap        = $urandom_range(1, 10);
                burst_left = $urandom_range(1, 24);
            end
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eot;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        items_sent++;
        tokenize_byte(c, eot);
    endtask

    function automatic void add_char(logic [7:0] c);
        lex_items.push_back({1'b0, c});
    endfunction

    function automatic void add_text(string s);
        foreach (s[i]) add_char(s[i]);
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) != 0) return 8'("a" + $urandom_range(0, 25));
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // one random lexeme, mostly well formed, sometimes noise or end of text
    function automatic void gen_lexeme();
        int unsigned pick;
        int unsigned n;
        int unsigned sel;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            add_text(kw_words[$urandom_range(0, 6)]);
            sel = $urandom_range(0, 3);
            if (sel == 1) add_char(rand_letter());
            else if (sel == 2) add_char(rand_digit());
        end else if (pick < 22) begin
            n = $urandom_range(1, 7);
            repeat (n) add_char(rand_letter());
        end else if (pick < 32) begin
            n = $urandom_range(1, 5);
            repeat (n) add_char(rand_digit());
            if ($urandom_range(0, 1) != 0) begin
                add_char(".");
                n = $urandom_range(0, 3);
                repeat (n) add_char(rand_digit());
                if ($urandom_range(0, 3) == 0) add_char(".");
            end
        end else if (pick < 42) begin
            add_char("\"");
            n = $urandom_range(0, 8);
            repeat (n) begin
                sel = $urandom_range(0, 5);
                case (sel)
                    0: begin add_char("\\"); add_char(8'($urandom_range(0, 255))); end
                    1: add_char("\n");
                    2: add_char(8'($urandom_range(0, 255)) & 8'h7F | 8'h20);
                    default: add_char(rand_letter());
                endcase
            end
            // a stray quote from the random byte just closes the string early
            if ($urandom_range(0, 6) != 0) add_char("\"");
        end else if (pick < 56) begin
            add_text(op_words[$urandom_range(0, 12)]);
        end else if (pick < 66) begin
            add_char(punct_chars[$urandom_range(0, 8)]);
        end else if (pick < 80) begin
            n = $urandom_range(1, 3);
            repeat (n) add_char(space_chars[$urandom_range(0, 5)]);
        end else if (pick < 85) begin
            add_text("//");
            n = $urandom_range(0, 10);
            repeat (n) add_char(8'($urandom_range(0, 255)));
            add_char("\n");
        end else if (pick < 88) begin
            add_text("#!");
            n = $urandom_range(0, 10);
            repeat (n) add_char(rand_letter());
            add_char("\n");
        end else if (pick < 93) begin
            add_text("/*");
            n = $urandom_range(0, 8);
            repeat (n) begin
                sel = $urandom_range(0, 3);
                case (sel)
                    0: add_char("*");
                    1: add_char("\n");
                    2: add_char("/");
                    default: add_char(rand_letter());
                endcase
            end
            if ($urandom_range(0, 1) != 0) add_char("*");
            add_text("*/");
        end else if (pick < 94) begin
            add_char("#");
        end else if (pick < 98) begin
            n = $urandom_range(1, 3);
            repeat (n) add_char(8'($urandom_range(0, 255)));
        end else begin
            lex_items.push_back({1'b1, 8'($urandom_range(0, 255))});
        end
        if ($urandom_range(0, 1) != 0) add_char(" ");
    endfunction

    // main sequence
    initial begin
        logic [8:0] item;
        int         k;
        tz_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_byte(dir_rows[r].ch, dir_rows[r].eot);
            if (dir_rows[r].typed && due_tokens.size() != 0) begin
                k = due_tokens.size() - 1;
                due_tokens[k].cls  = dir_rows[r].cls;
                due_tokens[k].op   = dir_rows[r].op;
                due_tokens[k].prec = dir_rows[r].prec;
                due_tokens[k].len  = dir_rows[r].len;
            end
        end

        // random source text
        while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
            gen_lexeme();
            while (lex_items.size() != 0) begin
                item = lex_items.pop_front();
                send_byte(item[7:0], item[8]);
            end
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);

        // line counter and token length both run into saturation
        send_byte("\"", 1'b0);
        repeat (SAT_RUN) send_byte("\n", 1'b0);
        send_byte("\"", 1'b0);
        send_byte(" ", 1'b0);
        repeat (SAT_RUN) send_byte(rand_digit(), 1'b0);
        send_byte(")", 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        s_axis_tvalid <= 1'b0;

        // drain
        while (due_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // ---------------- token checking ----------------

    function automatic void cmp_field(string fname, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", fname, want, got);
            fail_count++;
        end
    endfunction

    // receiver: check each token transfer, stall on a pattern, watch for a hang
    always @(posedge i_clk) begin
        tok_data_t got;
        token_t    want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = tok_data_t'(m_axis_tdata);
            if (due_tokens.size() == 0) begin
                $error("token with no expectation: class %0d", m_axis_tuser);
                fail_count++;
            end else begin
                want = due_tokens.pop_front();
                cmp_field("token_class", want.cls, m_axis_tuser);
                cmp_field("operator_code", want.op, got.op);
                cmp_field("precedence", want.prec, got.prec);
                cmp_field("line_number", want.line, got.line);
                cmp_field("start_offset", want.start, got.start);
                cmp_field("token_length", want.len, got.len);
                cmp_field("unterminated", want.unterm, got.unterm);
                cmp_field("last_of_run", want.last, m_axis_tlast);
            end
        end

        // stall style is picked anew whenever the run counter rx_left reaches zero
        if (rx_left == 0) begin
            rx_style = $urandom_range(0, 3);
            rx_left  = $urandom_range(32, 400);
        end else begin
            rx_left--;
        end
        case (rx_style)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rx_left % 8 < 5);
        endcase

        // watchdog on cycles without any transfer
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
